@@ rtl/ots_pkg.sv @@
package ots_pkg;

    localparam int unsigned MaxRes = 5;
    localparam int unsigned QDepth = 2;

    localparam logic [7:0] ChZero  = 8'h30;  // '0'
    localparam logic [7:0] ChSeven = 8'h37;  // '7'
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChBack  = 8'h5c;  // backslash
    localparam logic [7:0] ChNul   = 8'h00;

    localparam logic KindData = 1'b0;
    localparam logic KindEnd  = 1'b1;

    typedef enum logic [3:0] {
        M_SKIP  = 4'b0001,
        M_TOKEN = 4'b0010,
        M_ESC   = 4'b0100,
        M_DEAD  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
    } res_item_t;

    // results of one input request, item[0] goes out first
    typedef struct packed {
        logic [2:0]              count;
        res_item_t [MaxRes-1:0] item;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_req_t;

endpackage

@@ rtl/octal_escape_token_splitter_core.sv @@
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    in_byte[7:0], line_end
// out       out  out_valid / out_stall  out_byte[7:0], kind, last
//
// One input request per cycle is taken while the queue has room; a byte
// with no result never enters the queue, a byte with n results (up to 5)
// keeps the result port busy until all n have gone out.
// Reset (rst_n low, async) returns the scanner to skipping blanks and
// empties the queue. in_stall rises only when the 2-entry queue is full;
// out_stall freezes the current result, new input keeps flowing until the
// queue fills.
module octal_escape_token_splitter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       kind,
    output logic       last
);
    import ots_pkg::*;

    q_req_t push;
    q_req_t head;
    logic   q_full;
    logic   pop;
    logic   accept;

    // input side: scanner state moves only on an accepted request
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // front: tokenizer and escape decoder, builds the result list per byte
    ots_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .line_end (line_end),
        .push     (push)
    );

    // short queue decouples scanning from result delivery
    ots_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // back: sends the results of one list, one per cycle while out_stall is low, last on the final one
    ots_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .kind      (kind),
        .last      (last)
    );

endmodule

@@ rtl/ots_front.sv @@
module ots_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            line_end,
    output ots_pkg::q_req_t push
);
    import ots_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [5:0] held_reg, held_next;
    logic [1:0] cnt_reg, cnt_next;

    bundle_t    bun;
    logic       tok;
    logic       flush1;
    logic       is_blank, is_zero, is_bs, is_oct;
    logic [2:0] dig;

    function automatic bundle_t append(bundle_t b, logic [7:0] data, logic kind);
        bundle_t r;
        r = b;
        if (b.count < 3'(MaxRes))
        begin
            r.item[b.count] = '{data: data, kind: kind};
            r.count = b.count + 3'd1;
        end
        return r;
    endfunction

    // backslash, then held digits as literal characters
    function automatic bundle_t flush(bundle_t b, logic [5:0] held, logic [1:0] cnt);
        bundle_t r;
        r = append(b, ChBack, KindData);
        if (cnt[1])
        begin
            r = append(r, ChZero | {5'd0, held[5:3]}, KindData);
            r = append(r, ChZero | {5'd0, held[2:0]}, KindData);
        end
        else if (cnt[0])
        begin
            r = append(r, ChZero | {5'd0, held[2:0]}, KindData);
        end
        return r;
    endfunction

    assign is_blank = (in_byte == ChSpace) || (in_byte == ChTab);
    assign is_zero  = (in_byte == ChNul);
    assign is_bs    = (in_byte == ChBack);
    assign is_oct   = (in_byte >= ChZero) && (in_byte <= ChSeven);
    assign dig      = in_byte[2:0];

    always_comb
    begin
        bun       = '0;
        mode_next = mode_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        tok       = 1'b0;
        flush1    = 1'b0;

        unique case (mode_reg)
            M_TOKEN:
            begin
                tok = 1'b1;
            end
            M_ESC:
            begin
                if (is_oct && !cnt_reg[1])
                begin
                    held_next = {held_reg[2:0], dig};
                    cnt_next  = cnt_reg + 2'd1;
                end
                else if (is_oct && !held_reg[5])
                begin
                    // three digits, value fits a byte
                    bun       = append(bun, {held_reg[4:0], dig}, KindData);
                    held_next = '0;
                    cnt_next  = '0;
                    mode_next = M_TOKEN;
                end
                else
                begin
                    flush1 = 1'b1;
                    tok    = 1'b1;
                end
            end
            M_DEAD:
            begin
            end
            default:
            begin
                if (is_blank)
                begin
                end
                else if (is_zero)
                begin
                    mode_next = M_DEAD;
                end
                else
                begin
                    tok = 1'b1;
                end
            end
        endcase

        if (flush1)
        begin
            bun       = flush(bun, held_reg, cnt_reg);
            held_next = '0;
            cnt_next  = '0;
        end

        if (tok)
        begin
            priority if (is_blank)
            begin
                bun       = append(bun, 8'd0, KindEnd);
                mode_next = M_SKIP;
            end
            else if (is_zero)
            begin
                bun       = append(bun, 8'd0, KindEnd);
                mode_next = M_DEAD;
            end
            else if (is_bs)
            begin
                mode_next = M_ESC;
                held_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                bun       = append(bun, in_byte, KindData);
                mode_next = M_TOKEN;
            end
        end

        if (line_end)
        begin
            if (mode_next == M_ESC)
            begin
                bun = flush(bun, held_next, cnt_next);
                bun = append(bun, 8'd0, KindEnd);
            end
            else if (mode_next == M_TOKEN)
            begin
                bun = append(bun, 8'd0, KindEnd);
            end
            mode_next = M_SKIP;
            held_next = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_SKIP;
            held_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

    // requests with no result never enter the queue
    assign push.valid  = accept && (bun.count != 3'd0);
    assign push.bundle = bun;

endmodule

@@ rtl/ots_queue.sv @@
module ots_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ots_pkg::q_req_t push,
    input  logic            pop,
    output logic            full,
    output ots_pkg::q_req_t head
);
    import ots_pkg::*;

    localparam int unsigned PtrW = $clog2(QDepth);

    bundle_t         slot_reg [QDepth];
    logic [PtrW-1:0] wr_reg, wr_next;
    logic [PtrW-1:0] rd_reg, rd_next;
    logic [PtrW:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == (PtrW+1)'(QDepth));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (cnt_reg != '0);

    assign head.valid  = (cnt_reg != '0);
    assign head.bundle = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push.bundle;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(QDepth))
        else $error("queue count out of range");

endmodule

@@ rtl/ots_back.sv @@
module ots_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ots_pkg::q_req_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            kind,
    output logic            last
);
    import ots_pkg::*;

    bundle_t    cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       last_item, done;

    assign last_item = (idx_reg == cur_reg.count - 3'd1);
    assign done      = busy_reg && !out_stall && last_item;
    assign pop       = head.valid && (!busy_reg || done);

    always_comb
    begin
        cur_next  = pop ? head.bundle : cur_reg;
        busy_next = pop ? 1'b1 : (done ? 1'b0 : busy_reg);
        if (pop)
        begin
            idx_next = '0;
        end
        else if (busy_reg && !out_stall && !last_item)
        begin
            idx_next = idx_reg + 3'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign out_valid = busy_reg;
    assign out_byte  = cur_reg.item[idx_reg].data;
    assign kind      = cur_reg.item[idx_reg].kind;
    assign last      = last_item;

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < cur_reg.count))
        else $error("result index past bundle count");

    a_last_then_new: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_stall && !last_item) |=> (busy_reg && idx_reg == $past(idx_reg) + 3'd1))
        else $error("result index did not advance");

endmodule
